// ===== rtl/sapq_pkg.sv =====
package sapq_pkg;

   localparam logic [2:0] OP_ENQUEUE = 3'd0;
   localparam logic [2:0] OP_DEQUEUE = 3'd1;
   localparam logic [2:0] OP_READ    = 3'd2;
   localparam logic [2:0] OP_UPDATE  = 3'd3;
   localparam logic [2:0] OP_STATUS  = 3'd4;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 40;

   typedef struct packed {
      logic signed [15:0] prio;
      logic [31:0]        value;
   } entry_type;

   typedef struct packed {
      logic               enq;
      logic               deq;
      logic               upd;
      logic signed [15:0] prio;
      logic [31:0]        value;
   } cell_cmd_type;

endpackage

// ===== rtl/sapq_cell.sv =====
module sapq_cell
   import sapq_pkg::*;
(
   input  logic         clock,
   input  cell_cmd_type cmd,
   input  logic         occupied,
   input  logic         selected,
   input  logic         left_ins,
   input  entry_type    left_entry,
   input  entry_type    right_entry,
   output logic         ins,
   output entry_type    entry
);

   entry_type entry_ff;
   entry_type entry_in;

   assign ins   = !occupied || (entry_ff.prio < cmd.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.enq) begin
         if (left_ins) begin
            entry_in = left_entry;
         end else if (ins) begin
            entry_in.prio  = cmd.prio;
            entry_in.value = cmd.value;
         end
      end else if (cmd.deq) begin
         entry_in = right_entry;
      end else if (cmd.upd && selected) begin
         entry_in.value = cmd.value;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== rtl/sorted_array_priority_queue.sv =====
// Response: registered; it appears on rsp_tdata in the cycle after the request transfer.
// Throughput: one operation per cycle unless a stalled response holds req_tready
// low; enqueue shifts the cells from the insertion point on, dequeue the whole row.
// Reset: synchronous, active high; clears the entry count and the response
// valid flag. Cell contents stay undefined until written.
module sorted_array_priority_queue
   import sapq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // op[2:0], priority_req[18:3], value[50:19], position[54:51], zero[55]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // ok[0], value_out[32:1], entry_count[37:33], is_empty[38], is_full[39]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = (CW > 4) ? CW : 4;

   logic [2:0]        op;
   logic signed [15:0] prio;
   logic [31:0]       value;
   logic [3:0]        position;

   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     count_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   logic              accept;
   logic              full;
   logic              empty;
   logic              pos_ok;
   logic              ok;
   logic [31:0]       value_out;
   logic [31:0]       read_value;
   cell_cmd_type      cmd;

   entry_type         entries [DEPTH];
   logic [DEPTH-1:0]  ins;

   assign op       = req_tdata[2:0];
   assign prio     = req_tdata[18:3];
   assign value    = req_tdata[50:19];
   assign position = req_tdata[54:51];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign full       = (count_ff == CW'(DEPTH));
   assign empty      = (count_ff == '0);
   assign pos_ok     = (PW'(position) < PW'(count_ff));

   always_comb begin
      cmd.enq   = accept && (op == OP_ENQUEUE) && !full;
      cmd.deq   = accept && (op == OP_DEQUEUE) && !empty;
      cmd.upd   = accept && (op == OP_UPDATE) && pos_ok;
      cmd.prio  = prio;
      cmd.value = value;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic      left_ins;
      entry_type left_entry;
      entry_type right_entry;

      if (i == 0) begin : g_head
         assign left_ins   = 1'b0;
         assign left_entry = '0;
      end else begin : g_body
         assign left_ins   = ins[i-1];
         assign left_entry = entries[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_entry = '0;
      end else begin : g_mid
         assign right_entry = entries[i+1];
      end

      sapq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (CW'(i) < count_ff),
         .selected    (PW'(position) == PW'(i)),
         .left_ins    (left_ins),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .ins         (ins[i]),
         .entry       (entries[i])
      );
   end

   always_comb begin
      read_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (PW'(position) == PW'(i)) begin
            read_value = entries[i].value;
         end
      end
   end

   always_comb begin
      count_in  = count_ff;
      ok        = 1'b0;
      value_out = '0;
      case (op)
         OP_ENQUEUE: begin
            ok = !full;
            if (!full) begin
               count_in = count_ff + CW'(1);
            end
         end
         OP_DEQUEUE: begin
            ok = !empty;
            if (!empty) begin
               count_in  = count_ff - CW'(1);
               value_out = entries[0].value;
            end
         end
         OP_READ: begin
            ok = pos_ok;
            if (pos_ok) begin
               value_out = read_value;
            end
         end
         OP_UPDATE: begin
            ok = pos_ok;
         end
         OP_STATUS: begin
            ok = 1'b1;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_data_in       = rsp_data_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_tready;
      if (accept) begin
         rsp_valid_in      = 1'b1;
         rsp_data_in[0]    = ok;
         rsp_data_in[32:1] = value_out;
         rsp_data_in[37:33] = 5'(count_in);
         rsp_data_in[38]   = (count_in == '0);
         rsp_data_in[39]   = (count_in == CW'(DEPTH));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/sapq_checker.sv =====
module sapq_checker
   import sapq_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("transfer without response");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[38] && rsp_tdata[39]))
      else $error("empty and full together");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

endmodule

bind sorted_array_priority_queue sapq_checker u_sapq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
